// File: src/kgram_walk_counter_macros.svh
// Assertion macros for the walk counter checker.
// Depends on nothing; the asserting file supplies clock and reset.
`ifndef KGRAM_WALK_COUNTER_MACROS_SVH
`define KGRAM_WALK_COUNTER_MACROS_SVH

// Next-cycle implication, off while reset is high.
`define KWC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, off while reset is high.
`define KWC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check what reset leaves on the ports in the next cycle.
`define KWC_ASSERT_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

// File: src/kwc_pkg.sv
// Shared types and constants for the walk counter.
// Used by the controller, the datapath and the top level.
package kwc_pkg;

   localparam int CHAR_W      = 8;
   localparam int GRAM_W      = 64;
   localparam int COUNT_W     = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int STR_CNT_W   = 7;
   localparam int GRAM_LEN_W  = 4;
   localparam int TARGET_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STRING_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAM_LEN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LEN   = 2'd2;

   typedef struct packed {
      logic gram_wr;
      logic head_rd;
      logic step;
      logic first_col;
      logic last_col;
      logic first_round;
      logic last_round;
      logic par;
      logic init_total;
      logic init_to_n;
      logic emit;
   } ctl_cmd_type;

endpackage

// File: src/kwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/kwc_ctrl.sv
// Controller: configuration registers, request handshake, load index and
// the row / column / round sequencer. Depends on kwc_pkg.
module kwc_ctrl import kwc_pkg::*; #(
   parameter int MAX_GRAMS      = 64,
   parameter int MAX_GRAM_CHARS = 8,
   localparam int IW = $clog2(MAX_GRAMS),
   localparam int NW = $clog2(MAX_GRAMS + 1),
   localparam int KW = $clog2(MAX_GRAM_CHARS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ctl_cmd_type           cmd,
   output logic [IW-1:0]         rd_addr,
   output logic [IW-1:0]         row,
   output logic [IW-1:0]         load_addr,
   output logic [NW-1:0]         gram_n,
   output logic [KW-1:0]         gram_k
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_HEAD   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [STR_CNT_W-1:0]  str_cnt_ff, str_cnt_in;
   logic [GRAM_LEN_W-1:0] gram_len_ff, gram_len_in;
   logic [TARGET_W-1:0]   target_ff, target_in;
   logic [IW-1:0]         load_idx_ff, load_idx_in;
   logic [IW-1:0]         row_ff, row_in;
   logic [IW-1:0]         col_ff, col_in;
   logic [TARGET_W-1:0]   round_ff, round_in;
   logic [TARGET_W-1:0]   rounds_ff, rounds_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [KW-1:0]         k_ff, k_in;
   logic                  par_ff, par_in;
   logic                  first_ff, first_in;
   logic                  drain_ff, drain_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [NW-1:0]         eff_n;
   logic [KW-1:0]         eff_k;
   logic [TARGET_W-1:0]   rounds_calc;
   logic                  last_load;
   logic                  col_last, row_last, round_last;
   logic                  accept;

   // Clamp the configured count and length into the supported range, and derive the round count.
   always_comb begin
      if (str_cnt_ff == '0) begin
         eff_n = NW'(1);
      end else if (32'(str_cnt_ff) > MAX_GRAMS) begin
         eff_n = NW'(MAX_GRAMS);
      end else begin
         eff_n = NW'(str_cnt_ff);
      end
      if (gram_len_ff == '0) begin
         eff_k = KW'(1);
      end else if (32'(gram_len_ff) > MAX_GRAM_CHARS) begin
         eff_k = KW'(MAX_GRAM_CHARS);
      end else begin
         eff_k = KW'(gram_len_ff);
      end
      if (target_ff > TARGET_W'(eff_k)) begin
         rounds_calc = target_ff - TARGET_W'(eff_k);
      end else begin
         rounds_calc = '0;
      end
   end

   assign last_load  = ((NW+1)'(load_idx_ff) + (NW+1)'(1)) >= (NW+1)'(eff_n);
   assign col_last   = (NW'(col_ff) + NW'(1)) == n_ff;
   assign row_last   = (NW'(row_ff) + NW'(1)) == n_ff;
   assign round_last = round_ff == (rounds_ff - TARGET_W'(1));
   assign accept     = req_valid && !req_stall;

   always_comb begin
      str_cnt_in   = str_cnt_ff;
      gram_len_in  = gram_len_ff;
      target_in    = target_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STRING_COUNT: str_cnt_in  = csr_wdata[STR_CNT_W-1:0];
            CSR_GRAM_LEN:     gram_len_in = csr_wdata[GRAM_LEN_W-1:0];
            CSR_TARGET_LEN:   target_in   = csr_wdata[TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      load_idx_in  = load_idx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      round_in     = round_ff;
      rounds_in    = rounds_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      par_in       = par_ff;
      first_in     = first_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      rd_addr      = row_ff;
      cmd          = '0;
      cmd.par         = par_ff;
      cmd.first_round = first_ff;
      cmd.last_round  = round_last;

      case (state_ff)
         ST_IDLE: begin
            // Hold off the final gram until the result register is free.
            req_stall = rsp_valid_ff && last_load;
            if (accept) begin
               cmd.gram_wr = 1'b1;
               if (last_load) begin
                  load_idx_in    = '0;
                  n_in           = eff_n;
                  k_in           = eff_k;
                  rounds_in      = rounds_calc;
                  round_in       = '0;
                  row_in         = '0;
                  par_in         = 1'b0;
                  first_in       = 1'b1;
                  cmd.init_total = 1'b1;
                  cmd.init_to_n  = rounds_calc == '0;
                  state_in       = (rounds_calc == '0) ? ST_FINISH : ST_HEAD;
               end else begin
                  load_idx_in = load_idx_ff + IW'(1);
               end
            end
         end
         ST_HEAD: begin
            rd_addr     = row_ff;
            cmd.head_rd = 1'b1;
            col_in      = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr       = col_ff;
            cmd.step      = 1'b1;
            cmd.first_col = col_ff == '0;
            cmd.last_col  = col_last;
            if (col_last) begin
               if (row_last) begin
                  drain_in = 1'b0;
                  state_in = ST_DRAIN;
               end else begin
                  row_in   = row_ff + IW'(1);
                  state_in = ST_HEAD;
               end
            end else begin
               col_in = col_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            // Let the last row's sum reach the count store and the total.
            if (!drain_ff) begin
               drain_in = 1'b1;
            end else if (round_last) begin
               state_in = ST_FINISH;
            end else begin
               round_in = round_ff + TARGET_W'(1);
               par_in   = !par_ff;
               first_in = 1'b0;
               row_in   = '0;
               state_in = ST_HEAD;
            end
         end
         ST_FINISH: begin
            cmd.emit     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         str_cnt_ff   <= STR_CNT_W'(1);
         gram_len_ff  <= GRAM_LEN_W'(1);
         target_ff    <= '0;
         load_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         str_cnt_ff   <= str_cnt_in;
         gram_len_ff  <= gram_len_in;
         target_ff    <= target_in;
         load_idx_ff  <= load_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         drain_ff     <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      round_ff  <= round_in;
      rounds_ff <= rounds_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      par_ff    <= par_in;
      first_ff  <= first_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign row       = row_ff;
   assign load_addr = load_idx_ff;
   assign gram_n    = eff_n;
   assign gram_k    = k_ff;

endmodule

// File: src/kwc_dpath.sv
// Datapath: gram store, ping-pong count stores, overlap compare, row
// accumulator, running total and result register. Depends on kwc_pkg, kwc_ram.
module kwc_dpath import kwc_pkg::*; #(
   parameter int MAX_GRAMS      = 64,
   parameter int MAX_GRAM_CHARS = 8,
   localparam int IW = $clog2(MAX_GRAMS),
   localparam int NW = $clog2(MAX_GRAMS + 1),
   localparam int KW = $clog2(MAX_GRAM_CHARS + 1),
   localparam int GW = CHAR_W * MAX_GRAM_CHARS
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   input  logic [IW-1:0]      rd_addr,
   input  logic [IW-1:0]      row,
   input  logic [IW-1:0]      load_addr,
   input  logic [NW-1:0]      gram_n,
   input  logic [KW-1:0]      gram_k,
   input  logic [GRAM_W-1:0]  req_gram,
   output logic [COUNT_W-1:0] rsp_walk_count
);

   logic [GW-1:0]      gram_rd;
   logic [COUNT_W-1:0] cnt_a_rd, cnt_b_rd;
   logic [GW-1:0]      mask;
   logic [GW-1:0]      tail;
   logic               match;
   logic [COUNT_W-1:0] old_cnt, acc_next;

   logic               head_q_ff, step_ff, wr_ff;
   logic               first_col_ff, last_col_ff, first_round_ff, last_round_ff, par_ff;
   logic [IW-1:0]      row_q_ff;
   logic [IW-1:0]      wr_row_ff;
   logic               wr_par_ff, wr_last_round_ff;
   logic [GW-1:0]      head_ff;
   logic [COUNT_W-1:0] acc_ff, total_ff, walk_count_ff;

   kwc_ram #(.WIDTH(GW), .DEPTH(MAX_GRAMS)) u_gram_ram (
      .clock (clock),
      .we    (cmd.gram_wr),
      .waddr (load_addr),
      .wdata (req_gram[GW-1:0]),
      .raddr (rd_addr),
      .rdata (gram_rd)
   );

   // Count store A is the new store on odd rounds, B on even rounds.
   kwc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_GRAMS)) u_cnt_a_ram (
      .clock (clock),
      .we    (wr_ff && wr_par_ff),
      .waddr (wr_row_ff),
      .wdata (acc_ff),
      .raddr (rd_addr),
      .rdata (cnt_a_rd)
   );

   kwc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_GRAMS)) u_cnt_b_ram (
      .clock (clock),
      .we    (wr_ff && !wr_par_ff),
      .waddr (wr_row_ff),
      .wdata (acc_ff),
      .raddr (rd_addr),
      .rdata (cnt_b_rd)
   );

   // Overlap covers the first gram_len-1 characters.
   always_comb begin
      mask = '0;
      for (int c = 0; c < MAX_GRAM_CHARS; c++) begin
         if (c + 1 < int'(gram_k)) begin
            mask[c*CHAR_W +: CHAR_W] = '1;
         end
      end
   end

   assign tail    = (gram_rd >> CHAR_W) & mask;
   assign match   = head_ff == tail;
   assign old_cnt = first_round_ff ? COUNT_W'(1) : (par_ff ? cnt_b_rd : cnt_a_rd);
   assign acc_next = (first_col_ff ? '0 : acc_ff) + (match ? old_cnt : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_q_ff <= 1'b0;
         step_ff   <= 1'b0;
         wr_ff     <= 1'b0;
      end else begin
         head_q_ff <= cmd.head_rd;
         step_ff   <= cmd.step;
         wr_ff     <= step_ff && last_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      first_col_ff     <= cmd.first_col;
      last_col_ff      <= cmd.last_col;
      first_round_ff   <= cmd.first_round;
      last_round_ff    <= cmd.last_round;
      par_ff           <= cmd.par;
      row_q_ff         <= row;
      wr_row_ff        <= row_q_ff;
      wr_par_ff        <= par_ff;
      wr_last_round_ff <= last_round_ff;
      if (head_q_ff) begin
         head_ff <= gram_rd & mask;
      end
      if (step_ff) begin
         acc_ff <= acc_next;
      end
      if (cmd.init_total) begin
         total_ff <= cmd.init_to_n ? COUNT_W'(gram_n) : '0;
      end else if (wr_ff && wr_last_round_ff) begin
         total_ff <= total_ff + acc_ff;
      end
      if (cmd.emit) begin
         walk_count_ff <= total_ff;
      end
   end

   assign rsp_walk_count = walk_count_ff;

endmodule

// File: src/kgram_walk_counter.sv
// Top level of the k-gram walk counter: controller plus datapath.
// Depends on kwc_pkg, kwc_ctrl, kwc_dpath.
//
// Usage:
//  - Program string_count (index 0), gram_len (1) and target_len (2) on the
//    csr_ port while idle; each write lands at the clock edge of csr_wr_en.
//  - Send grams on req_valid / req_gram, one per cycle, while req_stall low.
//    Every request but the one that completes the set produces no response.
//  - The completing request starts the count. With R = target_len - gram_len
//    rounds and n grams, the single compare-and-add unit walks the graph one
//    (row, column) pair per cycle while scanning, with a head read per row and
//    a drain per round; then finish raises the response, directly if R = 0.
//  - req_stall stays high during the count, and also for a completing
//    request while an earlier response still holds rsp_valid.
//  - rsp_walk_count is held in a register; it stays put while rsp_stall is
//    high, and loading requests keep flowing meanwhile.
//  - Reset clears the configuration to its defaults, the load index and the
//    response valid; store contents are not cleared.
module kgram_walk_counter import kwc_pkg::*; #(
   parameter int MAX_GRAMS      = 64,
   parameter int MAX_GRAM_CHARS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [GRAM_W-1:0]     req_gram,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COUNT_W-1:0]    rsp_walk_count
);

   localparam int IW = $clog2(MAX_GRAMS);
   localparam int NW = $clog2(MAX_GRAMS + 1);
   localparam int KW = $clog2(MAX_GRAM_CHARS + 1);

   ctl_cmd_type   cmd;
   logic [IW-1:0] rd_addr, row, load_addr;
   logic [NW-1:0] gram_n;
   logic [KW-1:0] gram_k;

   kwc_ctrl #(.MAX_GRAMS(MAX_GRAMS), .MAX_GRAM_CHARS(MAX_GRAM_CHARS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .row       (row),
      .load_addr (load_addr),
      .gram_n    (gram_n),
      .gram_k    (gram_k)
   );

   kwc_dpath #(.MAX_GRAMS(MAX_GRAMS), .MAX_GRAM_CHARS(MAX_GRAM_CHARS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .row            (row),
      .load_addr      (load_addr),
      .gram_n         (gram_n),
      .gram_k         (gram_k),
      .req_gram       (req_gram),
      .rsp_walk_count (rsp_walk_count)
   );

endmodule

// File: src/kwc_checker.sv
// Port-level checks for kgram_walk_counter, bound to the top level.
// Depends on kwc_pkg and kgram_walk_counter_macros.svh.
`include "kgram_walk_counter_macros.svh"

module kwc_checker import kwc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  csr_wr_en,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [GRAM_W-1:0]     req_gram,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [COUNT_W-1:0]    rsp_walk_count
);

   logic req_wait;
   logic rsp_wait;

   assign req_wait = req_valid && req_stall;
   assign rsp_wait = rsp_valid && rsp_stall;

   `KWC_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_walk_count), "rsp moved")

   // A taken response is never followed by another in the next cycle.
   `KWC_ASSERT_NEXT(a_rsp_gap, rsp_valid && !rsp_stall, !rsp_valid, "back-to-back responses")

   `KWC_ASSERT_RESET(a_rsp_reset, !rsp_valid, "response valid after reset")

   `KWC_ASSERT_NEXT(a_req_hold, req_wait, req_valid && $stable(req_gram), "request moved")

   // The user must change the registers only while the block is idle; the block does not enforce it.
   `KWC_ASSERT_NOW(a_csr_idle, csr_wr_en, !rsp_valid && !req_stall, "register write while busy")

endmodule

bind kgram_walk_counter kwc_checker u_kwc_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_wr_en      (csr_wr_en),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_gram       (req_gram),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_walk_count (rsp_walk_count)
);
